/* design/ofifo_pkg.sv */
package ofifo_pkg;

  localparam int DEPTH    = 4096;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int PTR_W    = ADDR_W + 1;
  localparam int LG_REG_W = $clog2(ADDR_W + 1);
  localparam int DATA_W   = 8;
  localparam int OP_W     = 2;
  localparam int CFG_W    = 4;
  localparam int FILL_W   = 13;

  localparam logic [CFG_W-1:0] CAP_LG_RESET = CFG_W'(12);

  localparam logic [OP_W-1:0] OP_PUT   = OP_W'(0);
  localparam logic [OP_W-1:0] OP_GET   = OP_W'(1);
  localparam logic [OP_W-1:0] OP_CLEAR = OP_W'(2);

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] write_data;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              read_valid;
    logic [FILL_W-1:0] fill_count;
    logic              is_full;
    logic              empty;
    logic              discarded;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Zero reads as 1; anything above ADDR_W, the log2 of the store size, is clamped to it.
  function automatic logic [LG_REG_W-1:0] clamp_lg(input logic [CFG_W-1:0] v);
    logic [LG_REG_W-1:0] r;
    if (v == '0) begin
      r = LG_REG_W'(1);
    end else if (int'(v) > ADDR_W) begin
      r = LG_REG_W'(ADDR_W);
    end else begin
      r = LG_REG_W'(v);
    end
    return r;
  endfunction

endpackage

/* design/ofifo_ram.sv */
module ofifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ofifo_ctrl.sv */
module ofifo_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  ofifo_pkg::cmd_t                   cmd,
  input  logic                              cfg_we,
  input  logic [ofifo_pkg::CFG_W-1:0]       cfg_data,
  input  logic [ofifo_pkg::DATA_W-1:0]      ram_q,
  output ofifo_pkg::mem_req_t               mem_req,
  output logic                              busy,
  output logic                              done,
  output ofifo_pkg::rsp_t                   result
);

  localparam int PW = ofifo_pkg::PTR_W;
  localparam int AW = ofifo_pkg::ADDR_W;

  logic [ofifo_pkg::LG_REG_W-1:0] cap_lg;
  logic [PW-1:0] rd_ptr, wr_ptr, rd_ptr_next, wr_ptr_next;
  logic          flag, flag_next;
  logic [PW-1:0] cap, pmask, fill, fill_next;
  logic [AW-1:0] amask;
  logic          accept, got;

  logic                        res_valid;
  logic [ofifo_pkg::FILL_W-1:0] res_fill;
  logic                        res_full, res_empty, res_disc;

  assign accept = start && !busy;
  assign cap    = PW'(1) << cap_lg;
  // at full store size cap<<1 wraps to zero, giving all ones
  assign pmask  = (cap << 1) - PW'(1);
  assign amask  = AW'(cap - PW'(1));
  assign fill   = (wr_ptr - rd_ptr) & pmask;

  always_comb begin
    rd_ptr_next   = rd_ptr;
    wr_ptr_next   = wr_ptr;
    flag_next     = flag;
    got           = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = wr_ptr[AW-1:0] & amask;
    mem_req.wdata = cmd.write_data;
    mem_req.raddr = rd_ptr[AW-1:0] & amask;
    if (accept) begin
      unique case (cmd.opcode)
        ofifo_pkg::OP_PUT: begin
          if (fill >= cap) begin
            rd_ptr_next = (rd_ptr + PW'(1)) & pmask;
            flag_next   = 1'b1;
          end
          mem_req.we  = 1'b1;
          wr_ptr_next = (wr_ptr + PW'(1)) & pmask;
        end
        ofifo_pkg::OP_GET: begin
          if (fill != '0) begin
            got         = 1'b1;
            rd_ptr_next = (rd_ptr + PW'(1)) & pmask;
          end
        end
        ofifo_pkg::OP_CLEAR: begin
          flag_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
    fill_next = (wr_ptr_next - rd_ptr_next) & pmask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      flag   <= 1'b0;
      cap_lg <= ofifo_pkg::clamp_lg(ofifo_pkg::CAP_LG_RESET);
      done   <= 1'b0;
      busy   <= 1'b1;
    end else begin
      busy <= 1'b0;
      done <= accept;
      if (cfg_we) begin
        cap_lg <= ofifo_pkg::clamp_lg(cfg_data);
        rd_ptr <= '0;
        wr_ptr <= '0;
        flag   <= 1'b0;
      end else begin
        rd_ptr <= rd_ptr_next;
        wr_ptr <= wr_ptr_next;
        flag   <= flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_valid <= got;
    res_fill  <= ofifo_pkg::FILL_W'(fill_next);
    res_full  <= (fill_next == cap);
    res_empty <= (fill_next == '0);
    res_disc  <= flag_next;
  end

  // RAM data lands in the same cycle as the status registers
  always_comb begin
    result.read_data  = res_valid ? ram_q : '0;
    result.read_valid = res_valid;
    result.fill_count = res_fill;
    result.is_full    = res_full;
    result.empty      = res_empty;
    result.discarded  = res_disc;
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("no result after accepted beat");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= cap)
    else $error("fill level above capacity");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.is_full && result.empty))
    else $error("full and empty together");

  a_put_nonempty: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == ofifo_pkg::OP_PUT |=> !result.empty)
    else $error("empty after put");

  a_clear_flag: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == ofifo_pkg::OP_CLEAR |=> !result.discarded)
    else $error("flag still set after clear");

endmodule

/* design/overwrite_oldest_byte_fifo_core.sv */
// channel   signals                    direction  handshake
// command   start, busy, cmd           in         taken when start && !busy
// result    done, result               out        valid for the one cycle done is high
// config    cfg_we, cfg_data           in         written when cfg_we is high
//
// One command per cycle while busy is low; its result appears on the cycle after acceptance.
// Latency is set by the registered read port of the byte store.
// Synchronous reset clears pointers and flag and sets capacity to 4096; busy is high for
// one cycle after reset. The store itself is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module overwrite_oldest_byte_fifo_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  ofifo_pkg::cmd_t             cmd,
  output logic                        busy,
  output logic                        done,
  output ofifo_pkg::rsp_t             result,
  input  logic                        cfg_we,
  input  logic [ofifo_pkg::CFG_W-1:0] cfg_data
);

  ofifo_pkg::mem_req_t              mem_req;
  logic [ofifo_pkg::DATA_W-1:0]     ram_q;

  ofifo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .ram_q    (ram_q),
    .mem_req  (mem_req),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  ofifo_ram #(
    .WIDTH (ofifo_pkg::DATA_W),
    .DEPTH (ofifo_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (ram_q)
  );

endmodule
